// File: sv/dug_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dug_pkg
// Shared types, codes and constants of the delayed unlock gate.
// ----------------------------------------------------------------------------
package dug_pkg;

  localparam int unsigned ElapsedW  = 16;
  localparam int unsigned FailW     = 16;
  localparam int unsigned LockW     = 22;
  localparam int unsigned UntilW    = 31;
  localparam int unsigned ProgW     = 31;
  localparam int unsigned SecW      = 20;
  localparam int unsigned DelayMsW  = 30;
  localparam int unsigned CfgIdxW   = 3;

  localparam logic [ElapsedW-1:0] TickCapMs    = 16'd10000;
  localparam logic [FailW-1:0]    FailMax      = 16'hFFFF;
  localparam logic [FailW-1:0]    LockThresh   = 16'd3;
  localparam logic [3:0]          LockShiftMax = 4'd8;
  localparam logic [31:0]         LockBaseS    = 32'd15;
  localparam logic [31:0]         LockMaxS     = 32'd3600;
  localparam logic [31:0]         MsPerS       = 32'd1000;

  typedef enum logic [1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_AUTHORIZE = 2'd1,
    FUNC_REQUEST   = 2'd2,
    FUNC_CANCEL    = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_NOT_REQUESTED = 4'd1,
    ST_NOT_OPEN_YET  = 4'd2,
    ST_CLOSED        = 4'd3,
    ST_NO_AUTH       = 4'd4,
    ST_LOCKED_OUT    = 4'd5,
    ST_PW_REQUIRED   = 4'd6,
    ST_BAD_PW        = 4'd7,
    ST_NOT_APPLIC    = 4'd8,
    ST_ALREADY_PEND  = 4'd9
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REQUIRE_DELAY    = 3'd0,
    CFG_REQUIRE_PASSWORD = 3'd1,
    CFG_AUTH_CONFIGURED  = 3'd2,
    CFG_DELAY_SECONDS    = 3'd3,
    CFG_WINDOW_SECONDS   = 3'd4
  } cfg_idx_e;

  // Result beat payload, highest field first in the packed tdata.
  typedef struct packed {
    logic [UntilW-1:0] ms_until_change;
    logic [LockW-1:0]  lockout_ms_left;
    logic [FailW-1:0]  bad_pw_count;
    logic              unlock_open;
    logic              pending;
    status_e           status;
  } result_t;

  // Lockout length in ms for a shift of 0..8: min(15 << shift, 3600) s.
  function automatic logic [LockW-1:0] lock_ms(input logic [3:0] shift);
    logic [31:0] secs;
    secs = LockBaseS << shift;
    if (secs > LockMaxS) begin
      secs = LockMaxS;
    end
    return LockW'(secs * MsPerS);
  endfunction

endpackage

// File: sv/delayed_unlock_gate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delayed_unlock_gate
// Access gate with a delayed unlock window and a wrong-password lockout.
// ----------------------------------------------------------------------------
// Each event beat on the slave side (tick, authorize, request, cancel) yields
// exactly one result beat on the master side carrying the status and the
// gate state after the event. The block takes one event per clock while the
// master side keeps tready high: the state update and the result are computed
// in one pass from the state registers and the beat, and land in the result
// register at the accepting edge. The slave side stays ready whenever the
// result register is empty or being drained in the same cycle. Configuration
// is a plain write port; delay and window are converted to milliseconds when
// written, so the event path holds only adds, compares and selects.
// ----------------------------------------------------------------------------
module delayed_unlock_gate
  import dug_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [SecW-1:0]     cfg_wdata_i,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: [15:0] tick_ms, [16] password_present, [17] password_ok, [23:18] zero
  input  logic [23:0]         s_axis_tdata,
  // tuser: [1:0] func
  input  logic [1:0]          s_axis_tuser,

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: [3:0] status, [4] pending, [5] unlock_open, [21:6] bad_pw_count,
  //        [43:22] lockout_ms_left, [74:44] ms_until_change, [79:75] zero
  output logic [79:0]         m_axis_tdata
);

  // Configuration registers, with derived millisecond limits.
  logic                 req_delay_q, req_pw_q, auth_cfg_q;
  logic [SecW-1:0]      delay_s_q, window_s_q;
  logic [DelayMsW-1:0]  delay_ms_q;
  logic [ProgW-1:0]     close_ms_q;

  // Gate state.
  logic                 pend_q, pend_d;
  logic [ProgW-1:0]     prog_q, prog_d;
  logic [FailW-1:0]     fail_q, fail_d;
  logic [LockW-1:0]     lock_q, lock_d;

  // Result register.
  logic                 out_valid_q;
  result_t              out_q, res_d;

  logic                 accept;
  func_e                func;
  logic [ElapsedW-1:0]  elapsed;
  logic                 pw_present, pw_ok;

  assign func       = func_e'(s_axis_tuser);
  assign elapsed    = s_axis_tdata[15:0];
  assign pw_present = s_axis_tdata[16];
  assign pw_ok      = s_axis_tdata[17];

  // Take a new beat when the result slot is empty or drains this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q};

  // --------------------------------------------------------------------------
  // Configuration writes: convert seconds to ms on the way in.
  // --------------------------------------------------------------------------
  logic [SecW:0] close_s_wr;

  always_comb begin
    close_s_wr = {1'b0, delay_s_q} + {1'b0, window_s_q};
    if (cfg_index_i == CFG_DELAY_SECONDS) begin
      close_s_wr = {1'b0, cfg_wdata_i} + {1'b0, window_s_q};
    end else if (cfg_index_i == CFG_WINDOW_SECONDS) begin
      close_s_wr = {1'b0, delay_s_q} + {1'b0, cfg_wdata_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_delay_q <= 1'b1;
      req_pw_q    <= 1'b1;
      auth_cfg_q  <= 1'b0;
      delay_s_q   <= '0;
      window_s_q  <= '0;
      delay_ms_q  <= '0;
      close_ms_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_REQUIRE_DELAY:    req_delay_q <= cfg_wdata_i[0];
        CFG_REQUIRE_PASSWORD: req_pw_q    <= cfg_wdata_i[0];
        CFG_AUTH_CONFIGURED:  auth_cfg_q  <= cfg_wdata_i[0];
        CFG_DELAY_SECONDS: begin
          delay_s_q  <= cfg_wdata_i;
          delay_ms_q <= DelayMsW'(DelayMsW'(cfg_wdata_i) * DelayMsW'(MsPerS));
          close_ms_q <= ProgW'(ProgW'(close_s_wr) * ProgW'(MsPerS));
        end
        CFG_WINDOW_SECONDS: begin
          window_s_q <= cfg_wdata_i;
          close_ms_q <= ProgW'(ProgW'(close_s_wr) * ProgW'(MsPerS));
        end
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Password check, shared by authorize and request.
  // --------------------------------------------------------------------------
  status_e          pw_status;
  logic [FailW-1:0] pw_fail, fail_inc;
  logic [LockW-1:0] pw_lock;
  logic [3:0]       lock_shift;

  always_comb begin
    // Saturate the failure count at its maximum.
    fail_inc = (fail_q == FailMax) ? fail_q : fail_q + 16'd1;
    if (fail_inc >= LockThresh + 16'(LockShiftMax)) begin
      lock_shift = LockShiftMax;
    end else begin
      lock_shift = 4'(fail_inc - LockThresh);
    end
    pw_fail = fail_q;
    pw_lock = lock_q;
    priority if (!auth_cfg_q) begin
      pw_status = ST_NO_AUTH;
    end else if (lock_q != '0) begin
      pw_status = ST_LOCKED_OUT;
    end else if (!pw_present) begin
      pw_status = ST_PW_REQUIRED;
    end else if (pw_ok) begin
      pw_status = ST_OK;
      pw_fail   = '0;
    end else begin
      pw_status = ST_BAD_PW;
      pw_fail   = fail_inc;
      if (fail_inc >= LockThresh) begin
        pw_lock = lock_ms(lock_shift);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Event decode and state update.
  // --------------------------------------------------------------------------
  logic [ElapsedW-1:0] delta;
  logic [ProgW-1:0]    prog_sum;
  logic                win_now;
  logic [UntilW-1:0]   change_ms;
  status_e             status;

  assign win_now = pend_q && (prog_q >= ProgW'(delay_ms_q)) && (prog_q < close_ms_q);

  always_comb begin
    delta    = (elapsed < TickCapMs) ? elapsed : TickCapMs;
    prog_sum = prog_q + ProgW'(delta);
    pend_d   = pend_q;
    prog_d   = prog_q;
    fail_d   = fail_q;
    lock_d   = lock_q;
    status   = ST_OK;
    unique case (func)
      FUNC_TICK: begin
        // Lockout counts down by the raw elapsed time, floor at zero.
        lock_d = (lock_q > LockW'(elapsed)) ? lock_q - LockW'(elapsed) : '0;
        if (pend_q) begin
          if (prog_sum >= close_ms_q) begin
            pend_d = 1'b0;
            prog_d = '0;
          end else begin
            prog_d = prog_sum;
          end
        end
      end
      FUNC_AUTHORIZE: begin
        if (req_delay_q && !win_now) begin
          priority if (!pend_q) begin
            status = ST_NOT_REQUESTED;
          end else if (prog_q < ProgW'(delay_ms_q)) begin
            status = ST_NOT_OPEN_YET;
          end else begin
            status = ST_CLOSED;
          end
        end else if (req_pw_q) begin
          status = pw_status;
          fail_d = pw_fail;
          lock_d = pw_lock;
        end
      end
      FUNC_REQUEST: begin
        priority if (!req_delay_q) begin
          status = ST_NOT_APPLIC;
        end else if (pend_q) begin
          status = ST_ALREADY_PEND;
        end else begin
          if (req_pw_q) begin
            status = pw_status;
            fail_d = pw_fail;
            lock_d = pw_lock;
          end
          if (status == ST_OK) begin
            pend_d = 1'b1;
            prog_d = '0;
          end
        end
      end
      FUNC_CANCEL: begin
        pend_d = 1'b0;
        prog_d = '0;
      end
      default: ;
    endcase

    // Time to the next window edge, from the updated state.
    change_ms = '0;
    if (pend_d) begin
      if (prog_d < ProgW'(delay_ms_q)) begin
        change_ms = UntilW'(ProgW'(delay_ms_q) - prog_d);
      end else if (prog_d < close_ms_q) begin
        change_ms = UntilW'(close_ms_q - prog_d);
      end
    end

    res_d.status          = status;
    res_d.pending         = pend_d;
    res_d.unlock_open     = pend_d && (prog_d >= ProgW'(delay_ms_q)) && (prog_d < close_ms_q);
    res_d.bad_pw_count    = fail_d;
    res_d.lockout_ms_left = lock_d;
    res_d.ms_until_change = change_ms;
  end

  // --------------------------------------------------------------------------
  // State and result registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      prog_q      <= '0;
      fail_q      <= '0;
      lock_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pend_q      <= pend_d;
        prog_q      <= prog_d;
        fail_q      <= fail_d;
        lock_q      <= lock_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload needs no reset: hold it until the next accepted beat.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res_d;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An idle gate keeps no progress.
  a_idle_no_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_q |-> (prog_q == '0))
    else $error("progress held without a pending request");

  // A lockout only follows at least three failures.
  a_lock_needs_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lock_q != '0) |-> (fail_q >= LockThresh))
    else $error("lockout active with fewer than three failures");

  // A reported open window always belongs to a pending request.
  a_window_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!out_q.unlock_open || out_q.pending))
    else $error("window reported open without a pending request");

  // An accepted event always leaves a result waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted event produced no result");

endmodule

// File: dv/tb_delayed_unlock_gate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delayed_unlock_gate
// Self-checking testbench of the delayed unlock gate.
// ----------------------------------------------------------------------------
// A short table of directed events runs first, covering reset behavior,
// missing auth, the shortest lockout and zero-length windows. Six random
// phases follow, each under its own register setting. Every accepted event
// beat runs through a local model of the gate, and the predicted result is
// queued. Each result beat on the master side is compared field by field with
// the oldest queued prediction. Both sides idle at random but in the last two
// phases, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_delayed_unlock_gate
  import dug_pkg::*;
();

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned PhaseBeats   = 175;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned ReportMax    = 10;

  // Gate arithmetic constants.
  localparam longint unsigned MsInSec  = 1000;
  localparam int unsigned     TickCap  = 10000;
  localparam int unsigned     LockBase = 15;
  localparam int unsigned     LockTop  = 3600;
  localparam int unsigned     LockFrom = 3;
  localparam int unsigned     LockStep = 8;

  // Register settings per random phase: require_delay, require_password,
  // auth_configured, delay_seconds, window_seconds. Phase 4 draws its own
  // delay and window.
  localparam bit [SecW-1:0] PhaseRegs [6][5] = '{
    '{20'd1, 20'd1, 20'd1, 20'd1,       20'd1},
    '{20'd1, 20'd1, 20'd1, 20'd0,       20'd3},
    '{20'd1, 20'd1, 20'd1, 20'hFFFFF,   20'hFFFFF},
    '{20'd0, 20'd1, 20'd1, 20'd2,       20'd0},
    '{20'd1, 20'd0, 20'd0, 20'd0,       20'd0},
    '{20'd0, 20'd0, 20'd1, 20'd3,       20'd2}
  };

  typedef struct {
    bit              is_cfg;
    cfg_idx_e        idx;
    bit [SecW-1:0]   val;
    func_e           fn;
    bit [15:0]       elapsed;
    bit              present;
    bit              verified;
    bit              has_fixed;
    result_t         fixed;
  } plan_row_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [SecW-1:0]   cfg_wdata_i    = '0;
  logic              s_axis_tvalid  = 1'b0;
  logic              s_axis_tready;
  // tdata: [15:0] tick_ms, [16] password_present, [17] password_ok, [23:18] zero
  logic [23:0]       s_axis_tdata   = '0;
  // tuser: [1:0] func
  logic [1:0]        s_axis_tuser   = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready  = 1'b0;
  // tdata: [3:0] status, [4] pending, [5] unlock_open, [21:6] bad_pw_count,
  //        [43:22] lockout_ms_left, [74:44] ms_until_change, [79:75] zero
  logic [79:0]       m_axis_tdata;

  delayed_unlock_gate u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Gate model: registers and state as the block should hold them.
  // --------------------------------------------------------------------------
  bit                 need_delay = 1'b1;
  bit                 need_pw    = 1'b1;
  bit                 has_auth   = 1'b0;
  bit [SecW-1:0]      delay_s    = '0;
  bit [SecW-1:0]      window_s   = '0;

  bit                 armed        = 1'b0;
  longint unsigned    run_ms       = 0;
  bit [FailW-1:0]     misses       = '0;
  bit [LockW-1:0]     lock_ms_left = '0;

  result_t            due_results [$];
  plan_row_t          plan [$];
  int unsigned        tx_idle_pct = 35;
  int unsigned        rx_idle_pct = 73;
  bit                 rx_hold     = 1'b0;
  int unsigned        mismatches  = 0;
  int unsigned        results_seen = 0;
  int unsigned        cycle_count = 0;

  function automatic longint unsigned open_at_ms();
    return longint'(delay_s) * MsInSec;
  endfunction

  function automatic longint unsigned close_at_ms();
    return (longint'(delay_s) + longint'(window_s)) * MsInSec;
  endfunction

  function automatic bit gate_open();
    return armed && run_ms >= open_at_ms() && run_ms < close_at_ms();
  endfunction

  // Check order: no auth record, active lockout, missing password, verdict.
  function automatic status_e judge_password(bit present, bit verified);
    int unsigned shift;
    int unsigned secs;
    if (!has_auth) return ST_NO_AUTH;
    if (lock_ms_left != 0) return ST_LOCKED_OUT;
    if (!present) return ST_PW_REQUIRED;
    if (verified) begin
      misses = '0;
      return ST_OK;
    end
    if (misses != FailMax) misses = misses + 1'b1;
    if (misses >= LockFrom) begin
      shift = int'(misses) - LockFrom;
      if (shift > LockStep) shift = LockStep;
      secs = LockBase << shift;
      if (secs > LockTop) secs = LockTop;
      lock_ms_left = LockW'(secs * 1000);
    end
    return ST_BAD_PW;
  endfunction

  // Apply one event to the model and return the result beat it should cause.
  function automatic result_t gate_event_result(func_e fn, bit [15:0] elapsed,
                                                bit present, bit verified);
    status_e         st;
    longint unsigned change_ms;
    int unsigned     advance;
    result_t         r;
    st        = ST_OK;
    change_ms = 0;
    case (fn)
      FUNC_TICK: begin
        advance = (elapsed < TickCap) ? elapsed : TickCap;
        lock_ms_left = (lock_ms_left > elapsed) ? lock_ms_left - elapsed : '0;
        if (armed) begin
          run_ms += advance;
          if (run_ms >= close_at_ms()) begin
            armed  = 1'b0;
            run_ms = 0;
          end
        end
      end
      FUNC_AUTHORIZE: begin
        if (need_delay && !gate_open()) begin
          if (!armed) st = ST_NOT_REQUESTED;
          else if (run_ms < open_at_ms()) st = ST_NOT_OPEN_YET;
          else st = ST_CLOSED;
        end else if (need_pw) begin
          st = judge_password(present, verified);
        end
      end
      FUNC_REQUEST: begin
        if (!need_delay) begin
          st = ST_NOT_APPLIC;
        end else if (armed) begin
          st = ST_ALREADY_PEND;
        end else begin
          if (need_pw) st = judge_password(present, verified);
          if (st == ST_OK) begin
            armed  = 1'b1;
            run_ms = 0;
          end
        end
      end
      default: begin
        armed  = 1'b0;
        run_ms = 0;
      end
    endcase
    if (armed) begin
      if (run_ms < open_at_ms()) change_ms = open_at_ms() - run_ms;
      else if (run_ms < close_at_ms()) change_ms = close_at_ms() - run_ms;
    end
    r = '0;
    r.status          = st;
    r.pending         = armed;
    r.unlock_open     = gate_open();
    r.bad_pw_count    = misses;
    r.lockout_ms_left = lock_ms_left;
    r.ms_until_change = UntilW'(change_ms);
    return r;
  endfunction

  // Result with the window shut and nothing left to count down to.
  function automatic result_t plain_result(status_e st, bit pend, bit [FailW-1:0] fails,
                                           bit [LockW-1:0] lock);
    result_t r;
    r = '0;
    r.status          = st;
    r.pending         = pend;
    r.bad_pw_count    = fails;
    r.lockout_ms_left = lock;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  task automatic add_beat(func_e fn, bit [15:0] elapsed, bit present, bit verified,
                          bit has_fixed = 1'b0, result_t fixed = '0);
    plan_row_t row;
    row = '{is_cfg: 1'b0, idx: CFG_REQUIRE_DELAY, val: '0, fn: fn, elapsed: elapsed,
            present: present, verified: verified, has_fixed: has_fixed, fixed: fixed};
    plan.push_back(row);
  endtask

  task automatic add_cfg(cfg_idx_e idx, bit [SecW-1:0] val);
    plan_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, val: val, fn: FUNC_TICK, elapsed: '0,
            present: 1'b0, verified: 1'b0, has_fixed: 1'b0, fixed: '0};
    plan.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Write one register; the model follows at once since the gate is idle.
  task automatic write_reg(cfg_idx_e idx, bit [SecW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_REQUIRE_DELAY:    need_delay = val[0];
      CFG_REQUIRE_PASSWORD: need_pw    = val[0];
      CFG_AUTH_CONFIGURED:  has_auth   = val[0];
      CFG_DELAY_SECONDS:    delay_s    = val;
      CFG_WINDOW_SECONDS:   window_s   = val;
      default: ;
    endcase
  endtask

  // Offer one event beat, idling first at random, and queue its prediction
  // at the accepting edge. Leave tvalid high so back-to-back beats need no
  // second assignment in one step.
  task automatic send_beat(func_e fn, bit [15:0] elapsed, bit present, bit verified,
                           bit has_fixed, result_t fixed);
    result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, verified, present, elapsed};
    s_axis_tuser  <= fn;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = gate_event_result(fn, elapsed, present, verified);
    due_results.push_back(has_fixed ? fixed : predicted);
  endtask

  // Stop offering and wait for every queued result; each event gives one,
  // so an empty queue means the gate is idle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random backpressure, plus one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold) begin
        rx_hold = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[74:0];
      results_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax) begin
          $display("result %0d with nothing expected: st=%0d pend=%0b win=%0b",
                   results_seen, got.status, got.pending, got.unlock_open);
          $display("  fails=%0d lock=%0d chg=%0d",
                   got.bad_pw_count, got.lockout_ms_left, got.ms_until_change);
        end
      end else begin
        want = due_results.pop_front();
        if (got.status !== want.status || got.pending !== want.pending ||
            got.unlock_open !== want.unlock_open ||
            got.bad_pw_count !== want.bad_pw_count ||
            got.lockout_ms_left !== want.lockout_ms_left ||
            got.ms_until_change !== want.ms_until_change) begin
          mismatches++;
          if (mismatches <= ReportMax) begin
            $display("result %0d mismatch:", results_seen);
            $display("  expected st=%0d pend=%0b win=%0b fails=%0d lock=%0d chg=%0d",
                     want.status, want.pending, want.unlock_open,
                     want.bad_pw_count, want.lockout_ms_left, want.ms_until_change);
            $display("  got      st=%0d pend=%0b win=%0b fails=%0d lock=%0d chg=%0d",
                     got.status, got.pending, got.unlock_open,
                     got.bad_pw_count, got.lockout_ms_left, got.ms_until_change);
          end
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("delayed_unlock_gate regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    func_e       fn;
    bit [15:0]   elapsed;
    bit          present;
    bit          verified;
    int unsigned roll;
    bit [SecW-1:0] val;

    // Reset config: delay and password required, no auth record, zero times.
    add_beat(FUNC_TICK,      16'd0,     1'b0, 1'b0, 1'b1, plain_result(ST_OK, 0, 0, 0));
    add_beat(FUNC_AUTHORIZE, 16'd0,     1'b1, 1'b1, 1'b1,
             plain_result(ST_NOT_REQUESTED, 0, 0, 0));
    add_beat(FUNC_REQUEST,   16'd0,     1'b1, 1'b1, 1'b1, plain_result(ST_NO_AUTH, 0, 0, 0));
    add_beat(FUNC_CANCEL,    16'hFFFF,  1'b1, 1'b1, 1'b1, plain_result(ST_OK, 0, 0, 0));
    add_beat(FUNC_TICK,      16'hFFFF,  1'b1, 1'b1, 1'b1, plain_result(ST_OK, 0, 0, 0));
    add_cfg(CFG_AUTH_CONFIGURED, 20'd1);
    add_beat(FUNC_REQUEST,   16'd0,     1'b0, 1'b1, 1'b1,
             plain_result(ST_PW_REQUIRED, 0, 0, 0));
    // Zero delay and window: pending, never open, and the next tick ends it.
    add_beat(FUNC_REQUEST,   16'd0,     1'b1, 1'b1, 1'b1, plain_result(ST_OK, 1, 0, 0));
    add_beat(FUNC_REQUEST,   16'd0,     1'b1, 1'b1, 1'b1,
             plain_result(ST_ALREADY_PEND, 1, 0, 0));
    add_beat(FUNC_AUTHORIZE, 16'd0,     1'b1, 1'b1, 1'b1, plain_result(ST_CLOSED, 1, 0, 0));
    add_beat(FUNC_TICK,      16'd0,     1'b0, 1'b0, 1'b1, plain_result(ST_OK, 0, 0, 0));
    // Three bad passwords in a row start the shortest lockout.
    add_beat(FUNC_REQUEST,   16'd0,     1'b1, 1'b0, 1'b1, plain_result(ST_BAD_PW, 0, 1, 0));
    add_beat(FUNC_REQUEST,   16'd0,     1'b1, 1'b0, 1'b1, plain_result(ST_BAD_PW, 0, 2, 0));
    add_beat(FUNC_REQUEST,   16'd0,     1'b1, 1'b0, 1'b1,
             plain_result(ST_BAD_PW, 0, 3, 22'd15000));
    add_beat(FUNC_AUTHORIZE, 16'd0,     1'b1, 1'b1, 1'b1,
             plain_result(ST_NOT_REQUESTED, 0, 3, 22'd15000));
    add_beat(FUNC_REQUEST,   16'd0,     1'b1, 1'b1, 1'b1,
             plain_result(ST_LOCKED_OUT, 0, 3, 22'd15000));
    add_beat(FUNC_TICK,      16'd14999, 1'b0, 1'b0, 1'b1, plain_result(ST_OK, 0, 3, 22'd1));
    add_beat(FUNC_TICK,      16'd1,     1'b0, 1'b0, 1'b1, plain_result(ST_OK, 0, 3, 22'd0));
    // One second delay, two second window: walk through open and close.
    add_cfg(CFG_DELAY_SECONDS, 20'd1);
    add_cfg(CFG_WINDOW_SECONDS, 20'd2);
    add_beat(FUNC_REQUEST,   16'd0,     1'b1, 1'b1);
    add_beat(FUNC_AUTHORIZE, 16'd0,     1'b1, 1'b1);
    add_beat(FUNC_TICK,      16'd1000,  1'b0, 1'b0);
    add_beat(FUNC_AUTHORIZE, 16'd0,     1'b1, 1'b1);
    add_beat(FUNC_AUTHORIZE, 16'd0,     1'b1, 1'b0);
    add_beat(FUNC_TICK,      16'hFFFF,  1'b0, 1'b0);
    // No delay mode: request is not applicable, authorize checks only the password.
    add_cfg(CFG_REQUIRE_DELAY, 20'd0);
    add_beat(FUNC_REQUEST,   16'd0,     1'b1, 1'b1);
    add_beat(FUNC_AUTHORIZE, 16'd0,     1'b1, 1'b1);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the table under the first idling mix.
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_beat(plan[i].fn, plan[i].elapsed, plan[i].present, plan[i].verified,
                  plan[i].has_fixed, plan[i].fixed);
      end
    end

    // Random phases: two per idling mix, each under its own setting.
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      for (int r = 0; r < 5; r++) begin
        val = PhaseRegs[ph][r];
        if (ph == 4 && r >= int'(CFG_DELAY_SECONDS)) val = SecW'($urandom_range(4));
        write_reg(cfg_idx_e'(r), val);
      end
      case (ph / 2)
        0: begin
          tx_idle_pct = 35;
          rx_idle_pct = 73;
        end
        1: begin
          tx_idle_pct = 73;
          rx_idle_pct = 35;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      // Hold the result side long enough to fill the gate and stall its input.
      if (ph == 1) rx_hold = 1'b1;

      for (int n = 0; n < PhaseBeats; n++) begin
        roll = $urandom_range(99);
        if (roll < 45) fn = FUNC_TICK;
        else if (roll < 70) fn = FUNC_AUTHORIZE;
        else if (roll < 90) fn = FUNC_REQUEST;
        else fn = FUNC_CANCEL;
        // Mostly short ticks so windows open and close; some long ones to
        // hit the cap and clear lockouts.
        roll = $urandom_range(99);
        if (roll < 60) begin
          elapsed = 16'($urandom_range(1500));
        end else if (roll < 85) begin
          elapsed = 16'($urandom_range(65535));
        end else begin
          case ($urandom_range(4))
            0: elapsed = 16'd0;
            1: elapsed = 16'd9999;
            2: elapsed = 16'd10000;
            3: elapsed = 16'd10001;
            default: elapsed = 16'hFFFF;
          endcase
        end
        present  = ($urandom_range(99) < 85);
        verified = ($urandom_range(99) < 80);
        send_beat(fn, elapsed, present, verified, 1'b0, '0);
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("delayed_unlock_gate regression: pass");
    end else begin
      $display("delayed_unlock_gate regression: fail");
    end
    $finish;
  end

endmodule
